/* hdl/multibyte_delta_filter_top_macros.svh */
`ifndef MULTIBYTE_DELTA_FILTER_TOP_MACROS_SVH
`define MULTIBYTE_DELTA_FILTER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define MDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define MDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mdf_pkg.sv */
package mdf_pkg;

    localparam int MAX_ELEMENT_BYTES = 256;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_UNDO     = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] ELEMENT_BYTES_RST = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX          = SIZE_W'(MAX_ELEMENT_BYTES);

    // Command shared by every cell of the row.
    typedef struct packed {
        logic              load;
        logic              shift;
        logic [BYTE_W-1:0] wr_byte;
    } cell_cmd_t;

    // Control from the filter core to the row.
    typedef struct packed {
        logic              wr_en;
        logic              load;
        logic [POS_W-1:0]  wr_pos;
        logic [BYTE_W-1:0] wr_byte;
    } row_ctrl_t;

    // Clamp the configured element size to 1..MAX_ELEMENT_BYTES.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] s;
        s = n;
        if (n == '0)
            s = SIZE_W'(1);
        else if (n > SIZE_MAX)
            s = SIZE_MAX;
        return s;
    endfunction

endpackage

/* hdl/mdf_cell.sv */
module mdf_cell (
    input  logic                            clk,
    input  mdf_pkg::cell_cmd_t              cmd,
    input  logic                            wr_sel,
    input  logic [mdf_pkg::BYTE_W-1:0]      line_in,
    output logic [mdf_pkg::BYTE_W-1:0]      line_out
);

    // bank holds the prior byte at this cell's position; line is the
    // read-ahead copy that walks toward the head of the row.
    logic [mdf_pkg::BYTE_W-1:0] bank_reg;
    logic [mdf_pkg::BYTE_W-1:0] bank_next;
    logic [mdf_pkg::BYTE_W-1:0] line_reg;
    logic [mdf_pkg::BYTE_W-1:0] line_next;

    always_comb
    begin
        bank_next = wr_sel ? cmd.wr_byte : bank_reg;
        if (cmd.load)
            line_next = bank_next;
        else if (cmd.shift)
            line_next = line_in;
        else
            line_next = line_reg;
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        line_reg <= line_next;
    end

    assign line_out = line_reg;

endmodule

/* hdl/mdf_row.sv */
module mdf_row (
    input  logic                            clk,
    input  mdf_pkg::row_ctrl_t              ctrl,
    output logic [mdf_pkg::BYTE_W-1:0]      head_byte
);

    localparam int N = mdf_pkg::MAX_ELEMENT_BYTES;

    mdf_pkg::cell_cmd_t         cmd;
    logic [mdf_pkg::BYTE_W-1:0] line_q [N];

    // On each write, reload every line copy at element end, otherwise advance one place.
    always_comb
    begin
        cmd.load    = ctrl.wr_en & ctrl.load;
        cmd.shift   = ctrl.wr_en & ~ctrl.load;
        cmd.wr_byte = ctrl.wr_byte;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                       sel;
        logic [mdf_pkg::BYTE_W-1:0] from_right;

        assign sel = ctrl.wr_en && (ctrl.wr_pos == mdf_pkg::POS_W'(i));

        if (i == N - 1)
        begin : g_tail
            assign from_right = '0;
        end
        else
        begin : g_body
            assign from_right = line_q[i+1];
        end

        mdf_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .wr_sel   (sel),
            .line_in  (from_right),
            .line_out (line_q[i])
        );
    end

    assign head_byte = line_q[0];

endmodule

/* hdl/multibyte_delta_filter_top.sv */
// Each input transfer loads the output register, so its result appears there in the cycle after.
// Throughput: one byte per clock; in_ready is low only while a result waits on out_ready.
// The row of cells keeps the next prior byte at its head, so no read stall occurs.
// Reset clears position, carry and output valid, marks the first element, and sets
// element size 2 and diff mode; the stored prior bytes are not cleared.
`include "multibyte_delta_filter_top_macros.svh"

module multibyte_delta_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mdf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mdf_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                table_begin,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mdf_pkg::BYTE_W-1:0]          result_byte
);

    logic [mdf_pkg::SIZE_W-1:0] elem_bytes_reg;
    logic                       mode_undo_reg;
    logic [mdf_pkg::POS_W-1:0]  pos_reg;
    logic                       carry_reg;
    logic                       first_reg;
    logic                       out_valid_reg;
    logic [mdf_pkg::BYTE_W-1:0] result_reg;

    logic [mdf_pkg::POS_W-1:0]  pos_next;
    logic                       carry_next;
    logic                       first_next;

    logic                       in_fire;
    logic [mdf_pkg::SIZE_W-1:0] size;
    logic [mdf_pkg::POS_W-1:0]  pos_eff;
    logic                       carry_eff;
    logic                       first_eff;
    logic [mdf_pkg::BYTE_W-1:0] prev;
    logic [mdf_pkg::BYTE_W:0]   sum9;
    logic [mdf_pkg::BYTE_W:0]   diff9;
    logic [mdf_pkg::BYTE_W-1:0] res;
    logic [mdf_pkg::BYTE_W-1:0] wbyte;
    logic                       carry_calc;
    logic [mdf_pkg::POS_W:0]    pos_inc;
    logic                       elem_end;
    mdf_pkg::row_ctrl_t         row_ctrl;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;

    assign size      = mdf_pkg::eff_size(elem_bytes_reg);
    assign pos_eff   = table_begin ? '0 : pos_reg;
    assign carry_eff = table_begin ? 1'b0 : carry_reg;
    assign first_eff = table_begin ? 1'b1 : first_reg;

    assign sum9  = {1'b0, data_byte} + {1'b0, prev} + {{mdf_pkg::BYTE_W{1'b0}}, carry_eff};
    assign diff9 = {1'b0, data_byte} - {1'b0, prev} - {{mdf_pkg::BYTE_W{1'b0}}, carry_eff};

    always_comb
    begin
        if (first_eff)
        begin
            res        = data_byte;
            wbyte      = data_byte;
            carry_calc = carry_eff;
        end
        else if (mode_undo_reg)
        begin
            res        = sum9[mdf_pkg::BYTE_W-1:0];
            wbyte      = sum9[mdf_pkg::BYTE_W-1:0];
            carry_calc = sum9[mdf_pkg::BYTE_W];
        end
        else
        begin
            res        = diff9[mdf_pkg::BYTE_W-1:0];
            wbyte      = data_byte;
            carry_calc = diff9[mdf_pkg::BYTE_W];
        end
    end

    assign pos_inc  = {1'b0, pos_eff} + {{mdf_pkg::POS_W{1'b0}}, 1'b1};
    assign elem_end = mdf_pkg::SIZE_W'(pos_inc) >= size;

    always_comb
    begin
        if (elem_end)
        begin
            pos_next   = '0;
            carry_next = 1'b0;
            first_next = 1'b0;
        end
        else
        begin
            pos_next   = pos_inc[mdf_pkg::POS_W-1:0];
            carry_next = carry_calc;
            first_next = first_eff;
        end
    end

    always_comb
    begin
        row_ctrl.wr_en   = in_fire;
        row_ctrl.load    = elem_end;
        row_ctrl.wr_pos  = pos_eff;
        row_ctrl.wr_byte = wbyte;
    end

    mdf_row u_row (
        .clk       (clk),
        .ctrl      (row_ctrl),
        .head_byte (prev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_bytes_reg <= mdf_pkg::ELEMENT_BYTES_RST;
            mode_undo_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mdf_pkg::CFG_ELEMENT_BYTES)
                elem_bytes_reg <= cfg_data;
            else if (cfg_index == mdf_pkg::CFG_MODE_UNDO)
                mode_undo_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            carry_reg <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
            first_reg <= first_next;
        end
    end

    // Hold the result until the transfer on the output side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

    `MDF_ASSERT_NEXT(a_end_clears, in_fire && elem_end, pos_reg == '0 && !carry_reg && !first_reg, "element end did not clear position state")
    `MDF_ASSERT_NEXT(a_begin_marks_first, in_fire && table_begin && !elem_end, first_reg, "table start did not mark the first element")
    `MDF_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_reg, "accepted byte produced no result")
    `MDF_ASSERT_SAME(a_no_carry_in_first, carry_reg, !first_reg, "carry set inside the first element")

endmodule

/* tb/sv/multibyte_delta_filter_top_test.sv */
module multibyte_delta_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [mdf_pkg::CFG_IDX_W-1:0] CFG_SPARE = mdf_pkg::CFG_IDX_W'(2);
    localparam logic MODE_SUB = 1'b0;
    localparam logic MODE_ADD = 1'b1;
    localparam int TOTAL_BYTES = 1550;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mdf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mdf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [mdf_pkg::BYTE_W-1:0]     data_byte;
    logic                           table_begin;
    logic                           out_valid;
    logic                           out_ready;
    logic [mdf_pkg::BYTE_W-1:0]     result_byte;

    multibyte_delta_filter_top dut (.*);

    // Filter state as the block should hold it.
    logic [mdf_pkg::BYTE_W-1:0] prior_bytes [mdf_pkg::MAX_ELEMENT_BYTES];
    bit                         prior_written [mdf_pkg::MAX_ELEMENT_BYTES];
    logic [mdf_pkg::POS_W-1:0]  cur_pos;
    logic                       carry;
    logic                       first_elem;
    logic [mdf_pkg::SIZE_W-1:0] elem_size_reg;
    logic                       undo_mode;

    logic [mdf_pkg::BYTE_W-1:0] expected_bytes [$];
    int                         fail_count;
    int                         bytes_sent;
    bit                         tx_gaps;
    bit                         rx_gaps;
    int                         rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int elem_len();
        if (elem_size_reg == '0)
            return 1;
        if (elem_size_reg > mdf_pkg::MAX_ELEMENT_BYTES)
            return mdf_pkg::MAX_ELEMENT_BYTES;
        return elem_size_reg;
    endfunction

    function automatic logic [mdf_pkg::BYTE_W-1:0] filter_step(
        input logic [mdf_pkg::BYTE_W-1:0] b,
        input logic                       start);
        logic [mdf_pkg::BYTE_W-1:0] prev;
        logic [mdf_pkg::BYTE_W-1:0] res;
        logic [mdf_pkg::BYTE_W+1:0] acc;
        int                         nxt;
        if (start)
        begin
            cur_pos    = '0;
            carry      = 1'b0;
            first_elem = 1'b1;
        end
        prev = prior_bytes[cur_pos];
        if (first_elem)
        begin
            res = b;
            prior_bytes[cur_pos] = b;
        end
        else if (undo_mode == MODE_ADD)
        begin
            acc   = b + prev + carry;
            res   = acc[mdf_pkg::BYTE_W-1:0];
            carry = acc[mdf_pkg::BYTE_W];
            prior_bytes[cur_pos] = res;
        end
        else
        begin
            acc   = prev + carry;
            res   = b - prev - carry;
            carry = (b < acc);
            prior_bytes[cur_pos] = b;
        end
        prior_written[cur_pos] = 1'b1;
        nxt = cur_pos + 1;
        if (nxt >= elem_len())
        begin
            cur_pos    = '0;
            carry      = 1'b0;
            first_elem = 1'b0;
        end
        else
        begin
            cur_pos = mdf_pkg::POS_W'(nxt);
        end
        return res;
    endfunction

    task automatic send_byte(input logic [mdf_pkg::BYTE_W-1:0] b, input logic start_flag);
        logic start;
        start = start_flag;
        // restart the table rather than read a prior byte that was never stored
        if (!start && !first_elem && !prior_written[cur_pos])
            start = 1'b1;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        table_begin <= start;
        do @(posedge clk); while (!in_ready);
        expected_bytes.push_back(filter_step(b, start));
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
    endtask

    task automatic write_reg(input logic [mdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mdf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mdf_pkg::CFG_ELEMENT_BYTES: elem_size_reg = val;
            mdf_pkg::CFG_MODE_UNDO:     undo_mode = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        logic [mdf_pkg::BYTE_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("result_byte: no transfer expected, actual %02h", result_byte);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result_byte !== want)
                begin
                    $error("result_byte: expected %02h, actual %02h", want, result_byte);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            if (rx_hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Default size 2 in diff mode with no table flag: the stream starts as a table.
    task automatic test_startup_borrow();
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    // Carry across bytes in undo mode, then drop back to diff mid-element.
    task automatic test_carry_mode_switch();
        write_reg(mdf_pkg::CFG_MODE_UNDO, mdf_pkg::CFG_DATA_W'(MODE_ADD));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        write_reg(mdf_pkg::CFG_MODE_UNDO, {8'hFF, MODE_SUB});
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    // Size zero acts as one; sizes above the maximum saturate.
    task automatic test_size_limits();
        write_reg(mdf_pkg::CFG_ELEMENT_BYTES, '0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
        write_reg(CFG_SPARE, 9'h155);
        write_reg(mdf_pkg::CFG_ELEMENT_BYTES, 9'h1FF);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_idle();
    endtask

    // Shrink the element while the position already lies past the new last byte.
    task automatic test_size_shrink();
        write_reg(mdf_pkg::CFG_ELEMENT_BYTES, 9'd3);
        send_byte(8'h10, 1'b1);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        wait_idle();
        write_reg(mdf_pkg::CFG_ELEMENT_BYTES, 9'd2);
        send_byte(8'h33, 1'b0);
        send_byte(8'h05, 1'b0);
        wait_idle();
    endtask

    // Hold the output long enough that the input stalls, then pause until drained.
    task automatic test_backpressure();
        int i;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        write_reg(mdf_pkg::CFG_ELEMENT_BYTES, 9'd4);
        write_reg(mdf_pkg::CFG_MODE_UNDO, mdf_pkg::CFG_DATA_W'(MODE_ADD));
        rx_hold = 120;
        for (i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, 255)), i == 0);
        wait_idle();
        for (i = 0; i < 20; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_tables();
        int target;
        int pick;
        int new_size;
        int n_tables;
        int t;
        int i;
        int sz;
        int len;
        bit big;
        bit big_done;
        bit cont;
        bit noisy;
        big_done = 1'b0;
        target = TOTAL_BYTES;
        while (bytes_sent < target)
        begin
            wait_idle();
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            big = 1'b0;
            pick = $urandom_range(0, 15);
            if (pick < 10)
                new_size = $urandom_range(1, 8);
            else if (pick < 13)
                new_size = $urandom_range(9, 40);
            else if (pick == 13)
                new_size = 0;
            else if (pick == 15 && !big_done)
            begin
                new_size = $urandom_range(256, 511);
                big = 1'b1;
                big_done = 1'b1;
            end
            else
                new_size = 1;
            if (big || $urandom_range(0, 3) != 0)
                write_reg(mdf_pkg::CFG_ELEMENT_BYTES, mdf_pkg::CFG_DATA_W'(new_size));
            if ($urandom_range(0, 1) == 0)
                write_reg(mdf_pkg::CFG_MODE_UNDO,
                          mdf_pkg::CFG_DATA_W'($urandom_range(0, 511)));
            // now and then carry the open table across the register change
            cont = ($urandom_range(0, 3) == 0);
            n_tables = big ? 1 : $urandom_range(1, 4);
            for (t = 0; t < n_tables; t++)
            begin
                sz = elem_len();
                len = sz * ((sz > 64) ? 2 : $urandom_range(1, 6));
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, len + sz);
                noisy = ($urandom_range(0, 9) == 0);
                for (i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)),
                              (i == 0 && !(cont && t == 0)) ||
                              (noisy && $urandom_range(0, 15) == 0));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        table_begin   = 1'b0;
        cur_pos       = '0;
        carry         = 1'b0;
        first_elem    = 1'b1;
        elem_size_reg = mdf_pkg::ELEMENT_BYTES_RST;
        undo_mode     = MODE_SUB;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_borrow();
        test_carry_mode_switch();
        test_size_limits();
        test_size_shrink();
        test_backpressure();
        test_random_tables();

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/mdf_pkg.sv
hdl/mdf_cell.sv
hdl/mdf_row.sv
hdl/multibyte_delta_filter_top.sv
tb/sv/multibyte_delta_filter_top_test.sv
